### src/svfm_pkg.sv
// shared types and constants for the multimode state-variable filter
// no dependencies
`default_nettype none

package svfm_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned ACC_WIDTH_DEF    = 24;

  localparam int unsigned COEF_WIDTH = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned DEN_W      = 18;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned DIV_CNT_W  = 4;

  // f = (F_OFS + F_SLOPE * cutoff + half) >> 16
  localparam logic [31:0]          F_OFS    = 32'd5478027;
  localparam logic [15:0]          F_SLOPE  = 16'd44636;
  // 0.707 in q0.16
  localparam logic [DEN_W-1:0]     DEN_BASE = 18'd46334;
  localparam logic [COEF_WIDTH-1:0] F_RESET  = 16'd84;
  localparam logic [COEF_WIDTH-1:0] FB_RESET = 16'd46348;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF    = 2'd0,
    REG_RESONANCE = 2'd1,
    REG_MODE      = 2'd2
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LP     = 3'd0,
    MODE_HP     = 3'd1,
    MODE_BP     = 3'd2,
    MODE_LP_HP  = 3'd3,
    MODE_LP_BP  = 3'd4,
    MODE_ALL    = 3'd5,
    MODE_HP_BP  = 3'd6,
    MODE_BYPASS = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    MUL_F_BAND  = 2'd0,
    MUL_F_HIGH  = 2'd1,
    MUL_FB_BAND = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load_sample;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_low;
    logic     upd_band;
    logic     upd_high;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### src/state_variable_filter_multimode.sv
// the filter takes one input word at a time, the next only as the last one's output word is
// loaded; the pace is set by the single shared multiplier and the low, band, high update order;
// a cutoff or resonance write stalls input while the coefficients are recomputed (two products,
// a setup state, 16 divider steps for the damping coefficient); reset: accumulators and settings
// cleared, coefficients at their reset-derived values; top level; depends on svfm_pkg, svfm_cfg, svfm_ctrl, svfm_dp
`default_nettype none

module state_variable_filter_multimode #(
  parameter int unsigned SAMPLE_WIDTH = svfm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH    = svfm_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]          sample_out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [svfm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [svfm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  svfm_pkg::mode_e                   mode;
  logic [svfm_pkg::COEF_WIDTH-1:0]   f_coef, fb_coef;
  logic                              cfg_busy;
  svfm_pkg::dp_cmd_t                 cmd;
  svfm_pkg::dp_status_t              status;

  svfm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_o      (mode),
    .f_o         (f_coef),
    .fb_o        (fb_coef),
    .busy_o      (cfg_busy)
  );

  svfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_busy_i (cfg_busy),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  svfm_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .f_i          (f_coef),
    .fb_i         (fb_coef),
    .mode_i       (mode),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire

### src/svfm_cfg.sv
// configuration registers and coefficient derivation (two registered multiplies, radix-2 divider)
// depends on svfm_pkg
`default_nettype none

module svfm_cfg (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [svfm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [svfm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output svfm_pkg::mode_e                            mode_o,
  output logic      [svfm_pkg::COEF_WIDTH-1:0]       f_o,
  output logic      [svfm_pkg::COEF_WIDTH-1:0]       fb_o,
  output logic                                       busy_o
);

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_MUL  = 4'b0010,
    CS_PREP = 4'b0100,
    CS_DIV  = 4'b1000
  } coef_state_e;

  coef_state_e state_q, state_d;

  logic [15:0]                         cutoff_q, resonance_q;
  svfm_pkg::mode_e                     mode_q;
  logic [svfm_pkg::COEF_WIDTH-1:0]     f_q, f_d;
  logic [svfm_pkg::COEF_WIDTH-1:0]     fb_q, fb_d;
  logic [svfm_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;

  logic [31:0]                         fq_prod_q, c2_prod_q;
  logic [svfm_pkg::DEN_W-1:0]          den_q, den_d;
  logic [svfm_pkg::DEN_W-1:0]          rem_q, rem_d;
  logic [15:0]                         num_lo_q, num_lo_d;
  logic [15:0]                         quo_q, quo_d;

  logic                                wr_coef;
  logic [32:0]                         fq_sum, c2_sum;
  logic [15:0]                         c2, damp;
  logic [svfm_pkg::DEN_W-1:0]          den_new;
  logic [31:0]                         num;
  logic [svfm_pkg::DEN_W:0]            trial;
  logic                                ge;
  logic [15:0]                         quo_next;
  logic                                last_step;

  assign wr_coef = cfg_we_i && (cfg_index_i == svfm_pkg::REG_CUTOFF ||
                                cfg_index_i == svfm_pkg::REG_RESONANCE);

  // coefficient terms
  assign fq_sum  = 33'(svfm_pkg::F_OFS) + 33'(fq_prod_q) + 33'd32768;
  assign c2_sum  = 33'(c2_prod_q) + 33'd32768;
  assign c2      = c2_sum[31:16];
  assign damp    = (resonance_q > c2) ? (resonance_q - c2) : 16'd0;
  assign den_new = svfm_pkg::DEN_BASE + {1'b0, damp, 1'b0};
  assign num     = 32'h8000_0000 + 32'(den_new >> 1);

  // one quotient bit a step
  assign trial     = {rem_q, num_lo_q[15]};
  assign ge        = trial >= {1'b0, den_q};
  assign quo_next  = {quo_q[14:0], ge};
  assign last_step = cnt_q == svfm_pkg::DIV_CNT_W'(svfm_pkg::DIV_STEPS - 1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    f_d      = f_q;
    fb_d     = fb_q;
    den_d    = den_q;
    rem_d    = rem_q;
    num_lo_d = num_lo_q;
    quo_d    = quo_q;
    unique case (state_q)
      CS_IDLE: begin
      end
      CS_MUL: begin
        state_d = CS_PREP;
      end
      CS_PREP: begin
        f_d      = fq_sum[31:16];
        den_d    = den_new;
        rem_d    = svfm_pkg::DEN_W'(num[31:16]);
        num_lo_d = num[15:0];
        quo_d    = '0;
        cnt_d    = '0;
        state_d  = CS_DIV;
      end
      CS_DIV: begin
        rem_d    = ge ? svfm_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[svfm_pkg::DEN_W-1:0];
        num_lo_d = {num_lo_q[14:0], 1'b0};
        quo_d    = quo_next;
        cnt_d    = cnt_q + 1'b1;
        if (last_step) begin
          fb_d    = quo_next;
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
    if (wr_coef) begin
      state_d = CS_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      cnt_q       <= '0;
      cutoff_q    <= '0;
      resonance_q <= '0;
      mode_q      <= svfm_pkg::MODE_LP;
      f_q         <= svfm_pkg::F_RESET;
      fb_q        <= svfm_pkg::FB_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      f_q     <= f_d;
      fb_q    <= fb_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          svfm_pkg::REG_CUTOFF:    cutoff_q    <= cfg_wdata_i[15:0];
          svfm_pkg::REG_RESONANCE: resonance_q <= cfg_wdata_i[15:0];
          svfm_pkg::REG_MODE:      mode_q      <= svfm_pkg::mode_e'(cfg_wdata_i[svfm_pkg::MODE_W-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fq_prod_q <= 32'(svfm_pkg::F_SLOPE) * 32'(cutoff_q);
    c2_prod_q <= 32'(cutoff_q) * 32'(cutoff_q);
    den_q     <= den_d;
    rem_q     <= rem_d;
    num_lo_q  <= num_lo_d;
    quo_q     <= quo_d;
  end

  assign mode_o = mode_q;
  assign f_o    = f_q;
  assign fb_o   = fb_q;
  assign busy_o = state_q != CS_IDLE;

endmodule

`default_nettype wire

### src/svfm_ctrl.sv
// sequencer for one filter step: handshake, multiplier schedule, output load
// depends on svfm_pkg
`default_nettype none

module svfm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 cfg_busy_i,
  input  svfm_pkg::dp_status_t      status_i,
  output logic                      in_stall_o,
  output svfm_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOW  = 6'b000010,
    ST_BAND = 6'b000100,
    ST_MULH = 6'b001000,
    ST_HIGH = 6'b010000,
    ST_OUT  = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        can_take;
  logic        accept;

  assign can_take = !cfg_busy_i &&
                    ((state_q == ST_IDLE) || (state_q == ST_OUT && status_i.out_free));
  assign accept   = in_valid_i && can_take;
  assign in_stall_o = !can_take;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        state_d = ST_LOW;
      end
      ST_LOW:  state_d = ST_BAND;
      ST_BAND: state_d = ST_MULH;
      ST_MULH: state_d = ST_HIGH;
      ST_HIGH: state_d = ST_OUT;
      ST_OUT: if (status_i.out_free) begin
        state_d = accept ? ST_LOW : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.load_sample = accept;
    cmd_o.mul_en      = accept || state_q == ST_LOW || state_q == ST_MULH;
    priority if (accept) begin
      cmd_o.mul_sel = svfm_pkg::MUL_F_BAND;
    end else if (state_q == ST_LOW) begin
      cmd_o.mul_sel = svfm_pkg::MUL_F_HIGH;
    end else begin
      cmd_o.mul_sel = svfm_pkg::MUL_FB_BAND;
    end
    cmd_o.upd_low  = state_q == ST_LOW;
    cmd_o.upd_band = state_q == ST_BAND;
    cmd_o.upd_high = state_q == ST_HIGH;
    cmd_o.load_out = state_q == ST_OUT && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### src/svfm_dp.sv
// filter datapath: three accumulators, one shared multiplier, output mixer and register
// depends on svfm_pkg
`default_nettype none

module svfm_dp #(
  parameter int unsigned SAMPLE_WIDTH = svfm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH    = svfm_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  svfm_pkg::dp_cmd_t                      cmd_i,
  output svfm_pkg::dp_status_t                   status_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  input  wire logic [svfm_pkg::COEF_WIDTH-1:0]   f_i,
  input  wire logic [svfm_pkg::COEF_WIDTH-1:0]   fb_i,
  input  svfm_pkg::mode_e                        mode_i,
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out_o
);

  localparam int unsigned FRAC_BITS = ACC_WIDTH - SAMPLE_WIDTH - 2;
  localparam int unsigned PW = ACC_WIDTH + svfm_pkg::COEF_WIDTH + 1;
  localparam int unsigned EW = ACC_WIDTH + 3;
  localparam int unsigned SW = ACC_WIDTH + 2;

  localparam logic [PW-1:0] HALF16   = PW'(1) << 15;
  localparam logic [PW-1:0] HALF15   = PW'(1) << 14;
  localparam logic [SW-1:0] HALF_OUT = (SW'(1) << FRAC_BITS) >> 1;

  localparam logic signed [EW-1:0] ACC_MAX = {4'b0000, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [EW-1:0] ACC_MIN = {4'b1111, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] OUT_MAX =
    {{(SW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] OUT_MIN =
    {{(SW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    r = v;
    if (v > ACC_MAX) begin
      r = ACC_MAX;
    end else if (v < ACC_MIN) begin
      r = ACC_MIN;
    end
    return r[ACC_WIDTH-1:0];
  endfunction

  logic signed [SAMPLE_WIDTH-1:0]      sample_q;
  logic signed [ACC_WIDTH-1:0]         low_q, band_q, high_q;
  logic signed [PW-1:0]                prod_q;
  logic signed [SAMPLE_WIDTH-1:0]      out_q, out_d;
  logic                                out_valid_q, out_valid_d;

  logic [svfm_pkg::COEF_WIDTH-1:0]     coef;
  logic signed [ACC_WIDTH-1:0]         opnd;
  logic signed [PW-1:0]                prod;
  logic signed [PW-1:0]                r16_full, r15_full;
  logic signed [EW-1:0]                r16, r15;
  logic signed [ACC_WIDTH-1:0]         scaled;
  logic signed [EW-1:0]                low_sum, band_sum, high_sum;
  logic signed [SW-1:0]                mix, mix_rnd;

  assign scaled = ACC_WIDTH'(sample_q) <<< FRAC_BITS;

  // shared multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      svfm_pkg::MUL_F_BAND: begin
        coef = f_i;
        opnd = band_q;
      end
      svfm_pkg::MUL_F_HIGH: begin
        coef = f_i;
        opnd = high_q;
      end
      svfm_pkg::MUL_FB_BAND: begin
        coef = fb_i;
        opnd = band_q;
      end
      default: begin
        coef = f_i;
        opnd = band_q;
      end
    endcase
  end

  assign prod = $signed({1'b0, coef}) * opnd;

  // rounded product terms
  assign r16_full = (prod_q + $signed(HALF16)) >>> 16;
  assign r15_full = (prod_q + $signed(HALF15)) >>> 15;
  assign r16      = r16_full[EW-1:0];
  assign r15      = r15_full[EW-1:0];

  assign low_sum  = EW'(low_q) - r16;
  assign band_sum = EW'(band_q) - r16;
  assign high_sum = r15 - EW'(low_q) - EW'(scaled);

  // output mixer
  always_comb begin
    unique case (mode_i)
      svfm_pkg::MODE_LP:     mix = SW'(low_q);
      svfm_pkg::MODE_HP:     mix = SW'(high_q);
      svfm_pkg::MODE_BP:     mix = SW'(band_q);
      svfm_pkg::MODE_LP_HP:  mix = SW'(low_q) + SW'(high_q);
      svfm_pkg::MODE_LP_BP:  mix = SW'(low_q) + SW'(band_q);
      svfm_pkg::MODE_ALL:    mix = SW'(low_q) + SW'(band_q) + SW'(high_q);
      svfm_pkg::MODE_HP_BP:  mix = SW'(band_q) + SW'(high_q);
      svfm_pkg::MODE_BYPASS: mix = SW'(scaled);
      default:               mix = SW'(scaled);
    endcase
  end

  assign mix_rnd = (mix + $signed(HALF_OUT)) >>> FRAC_BITS;

  always_comb begin
    if (mode_i == svfm_pkg::MODE_BYPASS) begin
      out_d = sample_q;
    end else if (mix_rnd > OUT_MAX) begin
      out_d = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (mix_rnd < OUT_MIN) begin
      out_d = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      out_d = mix_rnd[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      band_q      <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.upd_low) begin
        low_q <= sat_acc(low_sum);
      end
      if (cmd_i.upd_band) begin
        band_q <= sat_acc(band_sum);
      end
      if (cmd_i.upd_high) begin
        high_q <= sat_acc(high_sum);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_q;

endmodule

`default_nettype wire

### src/svfm_checker.sv
// port-level checks for the filter top level, attached by bind
// depends on svfm_pkg and state_variable_filter_multimode
`default_nettype none

module svfm_checker #(
  parameter int unsigned SAMPLE_WIDTH = svfm_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  input wire logic                              cfg_we_i,
  input wire logic [svfm_pkg::CFG_IDX_W-1:0]    cfg_index_i
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("output word changed while stalled");

  // one word in flight: input stalls through the LOW, BAND, MULH and HIGH states
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input taken during a filter step");

  // coefficient update blocks input
  a_coef_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == svfm_pkg::REG_CUTOFF ||
                 cfg_index_i == svfm_pkg::REG_RESONANCE) |=> in_stall_o)
    else $error("input taken while coefficients are updating");

  // no output word right after a reset edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind state_variable_filter_multimode svfm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_svfm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sample_out_o (sample_out_o),
  .cfg_we_i     (cfg_we_i),
  .cfg_index_i  (cfg_index_i)
);

`default_nettype wire
